/* sv/assert_macros.svh */
// Assertion macros shared by the audio gain and downmix RTL.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define AGM_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define AGM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define AGM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/agm_pkg.sv */
// Shared types, constants and sample helpers for the audio gain and downmix block.
// No dependencies; used by the divider and the top level.
package agm_pkg;

	// Datapath widths
	localparam int DIV_W = 40;   // dividend and quotient of the shared divider
	localparam int DVS_W = 8;    // divisor width (100 or a channel count)
	localparam int KS_W  = 33;   // signed sample value
	localparam int QS_W  = 36;   // signed scaled value before clamping
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 3;

	// Sample format codes
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_S8  = 3'd1;
	localparam logic [2:0] FMT_U16 = 3'd2;
	localparam logic [2:0] FMT_S16 = 3'd3;
	localparam logic [2:0] FMT_U32 = 3'd4;
	localparam logic [2:0] FMT_S32 = 3'd5;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MONO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FMT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP  = 3'd5;

	// Gain and reset constants
	localparam logic [7:0] GAIN_UNITY  = 8'd100;
	localparam logic [7:0] GAIN_MAX    = 8'd200;
	localparam logic [DVS_W-1:0] DVS_HUNDRED = 8'd100;
	localparam logic [3:0] CHAN_RESET  = 4'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CTR,
		ST_MUL,
		ST_GAIN_DIV,
		ST_GAIN_FIX,
		ST_MIX,
		ST_AVG_START,
		ST_AVG_DIV,
		ST_EMIT
	} agm_state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	// Keep only the bits of the format width
	function automatic logic [31:0] mask_sample(logic [31:0] v, logic [2:0] fmt);
		case (fmt)
			FMT_U8, FMT_S8:   mask_sample = {24'b0, v[7:0]};
			FMT_U16, FMT_S16: mask_sample = {16'b0, v[15:0]};
			default:          mask_sample = v;
		endcase
	endfunction

	// Reverse byte order of a masked sample
	function automatic logic [31:0] swap_sample(logic [31:0] v, logic [2:0] fmt);
		case (fmt)
			FMT_U16, FMT_S16: swap_sample = {16'b0, v[7:0], v[15:8]};
			FMT_U32, FMT_S32: swap_sample = {v[7:0], v[15:8], v[23:16], v[31:24]};
			default:          swap_sample = v;
		endcase
	endfunction

	// Interpret masked bits as a signed value
	function automatic logic signed [KS_W-1:0] decode_sample(logic [31:0] v, logic [2:0] fmt);
		case (fmt)
			FMT_S8:  decode_sample = {{25{v[7]}}, v[7:0]};
			FMT_S16: decode_sample = {{17{v[15]}}, v[15:0]};
			FMT_S32: decode_sample = {v[31], v};
			default: decode_sample = {1'b0, v};
		endcase
	endfunction

	// Center offset of unsigned formats; zero for signed ones
	function automatic logic [31:0] half_of(logic [2:0] fmt);
		case (fmt)
			FMT_U8:  half_of = 32'd127;
			FMT_U16: half_of = 32'd32767;
			FMT_U32: half_of = 32'h7fff_ffff;
			default: half_of = 32'd0;
		endcase
	endfunction

	function automatic logic signed [QS_W-1:0] clamp_lo(logic [2:0] fmt);
		case (fmt)
			FMT_S8:  clamp_lo = -36'sd128;
			FMT_S16: clamp_lo = -36'sd32768;
			FMT_S32: clamp_lo = -36'sd2147483648;
			default: clamp_lo = 36'sd0;
		endcase
	endfunction

	function automatic logic signed [QS_W-1:0] clamp_hi(logic [2:0] fmt);
		case (fmt)
			FMT_U8:  clamp_hi = 36'sd255;
			FMT_S8:  clamp_hi = 36'sd127;
			FMT_U16: clamp_hi = 36'sd65535;
			FMT_S16: clamp_hi = 36'sd32767;
			FMT_U32: clamp_hi = 36'sd4294967295;
			default: clamp_hi = 36'sd2147483647;
		endcase
	endfunction

endpackage

/* sv/agm_if.sv */
// Valid/ready stream interfaces for sample items and result items.
// No dependencies.
interface agm_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample_in;
	logic        last_of_buffer;

	modport source (output valid, sample_in, last_of_buffer, input ready);
	modport sink (input valid, sample_in, last_of_buffer, output ready);
endinterface

interface agm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample_out;
	logic        run_last;

	modport source (output valid, sample_out, run_last, input ready);
	modport sink (input valid, sample_out, run_last, output ready);
endinterface

/* sv/agm_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on agm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module agm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  agm_pkg::div_req_t req,
	output agm_pkg::div_rsp_t rsp
);
	import agm_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             ge;

	// Trial subtract of the divisor from the partial remainder
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = !diff[DVS_W];

	// Control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign rsp.busy     = (cnt_q != '0);
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`AGM_ASSERT_IMP(a_div_start_idle, req.start, cnt_q == '0 && !done_q, "divider started while busy")
	`AGM_ASSERT_IMP(a_div_nonzero, req.start, req.divisor != '0, "divider started with zero divisor")
	`AGM_ASSERT_IMP(a_div_done_after_busy, done_q, $past(cnt_q) == CNT_W'(1), "divider done out of order")

endmodule

/* sv/audio_gain_and_mono_downmix_top.sv */
// Top level of the audio gain and mono downmix block: config registers, sequencer,
// gain multiply, frame accumulator and output register. Depends on agm_pkg, agm_if,
// agm_div and assert_macros.svh.
//
// Channel   Dir  Handshake     Payload
// samples   in   valid/ready   sample_in[31:0], last_of_buffer
// results   out  valid/ready   sample_out[31:0], run_last
// config    in   wr_en only    wr_index[2:0], wr_data[7:0]
//
// Pass-through items (bad format, or no gain and no mixing) go straight to the emit
// state. Gain adds a multiply and a divide by 100 on the shared divider before the
// clamp; a mixed item that does not complete a frame only adds to the running sum. A
// frame-completing mixed item adds a division by the channel count. samples.ready is
// high only in the idle state; a finished item waits in the emit state while the output
// register still repeats an earlier result. Reset is asynchronous, active low.
`include "assert_macros.svh"

module audio_gain_and_mono_downmix_top #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [agm_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [agm_pkg::CFG_DATA_W-1:0]     wr_data,
	agm_in_if.sink                             samples,
	agm_out_if.source                          results
);
	import agm_pkg::*;

	localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int SUM_W = KS_W + $clog2(MAX_CHANNELS);

	// Configuration registers
	logic [7:0] gain_q;
	logic       scale_q;
	logic       mono_q;
	logic [2:0] fmt_q;
	logic [3:0] chan_q;
	logic       swap_q;

	// Sequencer and datapath registers
	agm_state_t               state_q, state_d;
	logic signed [KS_W-1:0]   k_q;
	logic [31:0]              dmag_q;
	logic                     neg_q;
	logic signed [QS_W-1:0]   qs_q;
	logic                     last_q;
	logic                     bypass_q;
	logic [CH_W-1:0]          emit_n_q;
	logic signed [SUM_W-1:0]  frame_sum_q;
	logic [CH_W-1:0]          pos_q;
	logic [31:0]              out_data_q;
	logic [CH_W-1:0]          out_cnt_q;

	// Derived controls
	logic [7:0]              gain_eff;
	logic [CH_W-1:0]         ch;
	logic                    gain_on;
	logic                    mono;
	logic                    fmt_ok;
	logic                    in_acc;
	logic                    out_hs;
	logic [31:0]             masked;
	logic [31:0]             swapped;
	logic [31:0]             half;
	logic signed [KS_W:0]    centered;
	logic [DIV_W-1:0]        prod;
	logic signed [SUM_W-1:0] sum_next;
	logic signed [SUM_W-1:0] sum_mag;
	logic [CH_W-1:0]         pos_inc;
	logic                    mix_done;
	logic signed [QS_W-1:0]  gain_q_signed;
	logic signed [QS_W-1:0]  offset_val;
	logic signed [QS_W-1:0]  lo;
	logic signed [QS_W-1:0]  hi;
	logic signed [QS_W-1:0]  clamped;
	logic signed [KS_W-1:0]  avg;
	logic [31:0]             enc_masked;
	logic [31:0]             encoded;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	assign gain_eff = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
	assign ch       = (32'(chan_q) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS) : CH_W'(chan_q);
	assign gain_on  = scale_q && (gain_eff != GAIN_UNITY);
	assign mono     = mono_q && (ch > CH_W'(1));
	assign fmt_ok   = (fmt_q <= FMT_S32);
	assign in_acc   = samples.valid && samples.ready;
	assign out_hs   = results.valid && results.ready;

	// Decode the incoming raw sample
	assign masked  = mask_sample(samples.sample_in, fmt_q);
	assign swapped = swap_q ? swap_sample(masked, fmt_q) : masked;
	assign half    = half_of(fmt_q);

	// Re-center and scale
	assign centered = {k_q[KS_W-1], k_q} - $signed({2'b0, half});
	assign prod     = {8'b0, dmag_q} * {32'b0, gain_eff};

	// Apply the sign, offset back and clamp to the format range
	assign gain_q_signed = neg_q ? -$signed({1'b0, div_rsp.quotient[QS_W-2:0]})
	                             : $signed({1'b0, div_rsp.quotient[QS_W-2:0]});
	assign offset_val = qs_q + $signed({4'b0, half});
	assign lo = clamp_lo(fmt_q);
	assign hi = clamp_hi(fmt_q);
	assign clamped = (offset_val < lo) ? lo : (offset_val > hi) ? hi : offset_val;

	// Frame accumulation
	assign sum_next = frame_sum_q + SUM_W'(k_q);
	assign pos_inc  = pos_q + 1'b1;
	assign mix_done = (pos_inc >= ch);
	assign sum_mag  = frame_sum_q[SUM_W-1] ? -frame_sum_q : frame_sum_q;
	assign avg = neg_q ? -$signed({1'b0, div_rsp.quotient[KS_W-2:0]})
	                   : $signed({1'b0, div_rsp.quotient[KS_W-2:0]});

	// Encode the result back into the sample's format and byte order
	assign enc_masked = mask_sample(k_q[31:0], fmt_q);
	assign encoded    = bypass_q ? k_q[31:0]
	                             : (swap_q ? swap_sample(enc_masked, fmt_q) : enc_masked);

	agm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_UNITY;
			scale_q <= 1'b0;
			mono_q  <= 1'b0;
			fmt_q   <= FMT_S16;
			chan_q  <= CHAN_RESET;
			swap_q  <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_GAIN:  gain_q  <= wr_data;
				REG_SCALE: scale_q <= wr_data[0];
				REG_MONO:  mono_q  <= wr_data[0];
				REG_FMT:   fmt_q   <= wr_data[2:0];
				REG_CHAN:  chan_q  <= wr_data[3:0];
				REG_SWAP:  swap_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider requests
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = prod;
		div_req.divisor  = DVS_HUNDRED;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!fmt_ok || (!gain_on && !mono)) begin
						state_d = ST_EMIT;
					end else if (gain_on) begin
						state_d = ST_CTR;
					end else begin
						state_d = ST_MIX;
					end
				end
			end
			ST_CTR: state_d = ST_MUL;
			ST_MUL: begin
				div_req.start = 1'b1;
				state_d       = ST_GAIN_DIV;
			end
			ST_GAIN_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_GAIN_FIX;
				end
			end
			ST_GAIN_FIX: state_d = mono ? ST_MIX : ST_EMIT;
			ST_MIX: state_d = mix_done ? ST_AVG_START : ST_IDLE;
			ST_AVG_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'($unsigned(sum_mag));
				div_req.divisor  = DVS_W'(ch);
				state_d          = ST_AVG_DIV;
			end
			ST_AVG_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_cnt_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Frame state: position and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_sum_q <= '0;
			pos_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// Drop the frame when not mixing
					if (in_acc && (!fmt_ok || !mono)) begin
						frame_sum_q <= '0;
						pos_q       <= '0;
					end
				end
				ST_MIX: begin
					if (mix_done) begin
						frame_sum_q <= sum_next;
						pos_q       <= pos_inc;
					end else if (last_q) begin
						frame_sum_q <= '0;
						pos_q       <= '0;
					end else begin
						frame_sum_q <= sum_next;
						pos_q       <= pos_inc;
					end
				end
				ST_AVG_START: begin
					frame_sum_q <= '0;
					pos_q       <= '0;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					last_q   <= samples.last_of_buffer;
					emit_n_q <= CH_W'(1);
					if (!fmt_ok) begin
						k_q      <= {1'b0, samples.sample_in};
						bypass_q <= 1'b1;
					end else if (!gain_on && !mono) begin
						k_q      <= {1'b0, masked};
						bypass_q <= 1'b1;
					end else begin
						k_q      <= decode_sample(swapped, fmt_q);
						bypass_q <= 1'b0;
					end
				end
			end
			ST_CTR: begin
				neg_q  <= centered[KS_W];
				dmag_q <= centered[KS_W] ? 32'(-centered) : 32'(centered);
			end
			ST_GAIN_DIV: begin
				if (div_rsp.done) begin
					qs_q <= gain_q_signed;
				end
			end
			ST_GAIN_FIX: begin
				k_q <= clamped[KS_W-1:0];
			end
			ST_AVG_START: begin
				neg_q    <= frame_sum_q[SUM_W-1];
				emit_n_q <= ch;
			end
			ST_AVG_DIV: begin
				if (div_rsp.done) begin
					k_q <= avg;
				end
			end
			default: ;
		endcase
	end

	// Output register: hold one result; a downmix result is repeated per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (state_q == ST_EMIT && out_cnt_q == '0) begin
			out_cnt_q <= emit_n_q;
		end else if (out_hs) begin
			out_cnt_q <= out_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_cnt_q == '0) begin
			out_data_q <= encoded;
		end
	end

	assign samples.ready      = (state_q == ST_IDLE);
	assign results.valid      = (out_cnt_q != '0);
	assign results.sample_out = out_data_q;
	assign results.run_last   = (out_cnt_q == CH_W'(1));

	`AGM_ASSERT_NXT(a_busy_after_accept, in_acc, state_q != ST_IDLE, "sequencer idle after accept")
	`AGM_ASSERT(a_emit_bound, out_cnt_q <= CH_W'(MAX_CHANNELS), "result repeat count too large")
	`AGM_ASSERT_NXT(a_gain_fix, state_q == ST_GAIN_DIV && div_rsp.done,
		state_q == ST_GAIN_FIX, "gain division not followed by clamp")
	`AGM_ASSERT_IMP(a_div_owned, div_rsp.busy,
		state_q == ST_GAIN_DIV || state_q == ST_AVG_DIV, "divider busy outside a divide state")

endmodule
